@@ hdl/sspt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspt_pkg
// Shared types and constants of the sequential servo pulse train.
// ----------------------------------------------------------------------------
package sspt_pkg;

  localparam int CHANNELS_DEF    = 7;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int CH_BITS    = 3;
  localparam int WIDTH_BITS = 12;
  localparam int TICK_BITS  = 16;
  localparam int PORT_BITS  = 8;

  localparam logic [TICK_BITS-1:0]  WIDTH_OFFSET = 16'd500;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 12'd1500;
  localparam logic [TICK_BITS-1:0]  WIDTH_MAX    = 16'd4095;
  localparam logic [TICK_BITS-1:0]  GAP_RESET    = 16'd20000;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_e;

  typedef struct packed {
    logic                step;
    action_e             action;
    logic [CH_BITS-1:0]  channel;
  } cmd_t;

  function automatic logic [PORT_BITS-1:0] chan_port(input logic [CH_BITS-1:0] ch);
    logic [PORT_BITS-1:0] v;
    v = '0;
    v[0] = 1'b1;
    v[ch + CH_BITS'(1)] = 1'b1;
    return v;
  endfunction

endpackage

@@ hdl/sspt_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspt_seq
// Frame sequencer: width table, gap/train phase, tick counter, port value.
// ----------------------------------------------------------------------------
module sspt_seq #(
  parameter int CHANNELS    = sspt_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = sspt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sspt_pkg::cmd_t                       cmd_i,
  input  logic [SAMPLE_BITS-1:0]               sample_i,
  input  logic [sspt_pkg::TICK_BITS-1:0]       gap_i,
  output logic [sspt_pkg::PORT_BITS-1:0]       port_d_o
);

  localparam int TB = sspt_pkg::TICK_BITS;
  localparam int CB = sspt_pkg::CH_BITS;
  localparam int WB = sspt_pkg::WIDTH_BITS;
  localparam int PB = sspt_pkg::PORT_BITS;
  localparam logic [CB-1:0] LAST_CH = CB'(CHANNELS - 1);

  logic [WB-1:0] width_q [CHANNELS];
  logic          train_q, train_d;
  logic [CB-1:0] active_q, active_d;
  logic [TB-1:0] tick_q, tick_d;
  logic [PB-1:0] port_q, port_d;

  logic [TB-1:0] tick_inc, gap_eff, width_raw, active_width;
  logic [WB-1:0] width_new;

  assign width_raw = (TB'(sample_i) << 1) + sspt_pkg::WIDTH_OFFSET;
  assign width_new = (width_raw > sspt_pkg::WIDTH_MAX) ? WB'(sspt_pkg::WIDTH_MAX)
                                                        : width_raw[WB-1:0];
  assign gap_eff   = (gap_i == '0) ? TB'(1) : gap_i;
  assign tick_inc  = tick_q + TB'(1);
  assign active_width = (32'(active_q) < CHANNELS) ? TB'(width_q[active_q]) : '0;

  always_comb begin
    train_d  = train_q;
    active_d = active_q;
    tick_d   = tick_q;
    port_d   = port_q;
    if (cmd_i.step && cmd_i.action == sspt_pkg::ACT_TICK) begin
      tick_d = tick_inc;
      if (!train_q) begin
        if (tick_inc >= gap_eff) begin
          train_d  = 1'b1;
          active_d = '0;
          tick_d   = '0;
          port_d   = sspt_pkg::chan_port('0);
        end
      end else if (32'(active_q) >= CHANNELS) begin
        train_d = 1'b0;
        tick_d  = '0;
        port_d  = '0;
      end else if (tick_inc >= active_width) begin
        tick_d = '0;
        if (active_q != LAST_CH) begin
          active_d = active_q + CB'(1);
          port_d   = sspt_pkg::chan_port(active_q + CB'(1));
        end else begin
          train_d = 1'b0;
          port_d  = '0;
        end
      end
    end
  end

  assign port_d_o = port_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      train_q  <= 1'b0;
      active_q <= '0;
      tick_q   <= '0;
      port_q   <= '0;
    end else begin
      train_q  <= train_d;
      active_q <= active_d;
      tick_q   <= tick_d;
      port_q   <= port_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) width_q[c] <= sspt_pkg::WIDTH_RESET;
    end else if (cmd_i.step && cmd_i.action == sspt_pkg::ACT_LOAD &&
                 32'(cmd_i.channel) < CHANNELS) begin
      width_q[cmd_i.channel] <= width_new;
    end
  end

  a_gap_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !train_q |-> port_q == '0)
    else $error("port not low during gap");

  a_train_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    train_q |-> port_q[0] && $onehot(port_q[PB-1:1]))
    else $error("train port value malformed");

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    train_q |-> 32'(active_q) < CHANNELS)
    else $error("active channel out of range");

  a_load_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && cmd_i.action == sspt_pkg::ACT_LOAD |=> $stable(port_q) && $stable(tick_q))
    else $error("load changed timing state");

endmodule

@@ hdl/sequential_servo_pulse_train.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_servo_pulse_train
// Seven-channel servo pulse sequencer: ticks advance the frame, loads set
// channel pulse widths; one port value returned per request.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata / data                     | tuser
//  s_axis   | in  | [2:0] channel, [SB+2:3] sample   | action (0 tick, 1 load)
//  m_axis   | out | [7:0] port_bits                  | -
//  cfg      | in  | [15:0] gap_ticks                 | -
//
//  One request per cycle while m_axis_tready is high; the result is valid
//  after the input register and then the result register, and can be taken
//  at the next edge. The sequencer update is combinational between them.
//  Reset: gap 20000, widths 1500, gap phase, port low.
//  m_axis_tready low stalls both stages; s_axis_tready drops only when full.
// ----------------------------------------------------------------------------
module sequential_servo_pulse_train #(
  parameter int CHANNELS    = sspt_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = sspt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((3+SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,   // channel, sample
  input  logic                                 s_axis_tuser,   // action
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [sspt_pkg::PORT_BITS-1:0]       m_axis_tdata,   // port_bits
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sspt_pkg::TICK_BITS-1:0]       cfg_data_i      // gap_ticks
);

  localparam int CB = sspt_pkg::CH_BITS;

  logic                            in_valid_q;
  sspt_pkg::action_e               in_action_q;
  logic [CB-1:0]                   in_channel_q;
  logic [SAMPLE_BITS-1:0]          in_sample_q;
  logic                            out_valid_q;
  logic [sspt_pkg::PORT_BITS-1:0]  out_data_q;
  logic [sspt_pkg::TICK_BITS-1:0]  gap_q;
  logic                            out_free, fire;
  sspt_pkg::cmd_t                  cmd;
  logic [sspt_pkg::PORT_BITS-1:0]  port_next;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  assign cmd.step    = fire;
  assign cmd.action  = in_action_q;
  assign cmd.channel = in_channel_q;

  sspt_seq #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (in_sample_q),
    .gap_i    (gap_q),
    .port_d_o (port_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= sspt_pkg::GAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q  <= sspt_pkg::action_e'(s_axis_tuser);
      in_channel_q <= s_axis_tdata[CB-1:0];
      in_sample_q  <= s_axis_tdata[CB+SAMPLE_BITS-1:CB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= port_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("pending request dropped");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed request produced no result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(out_data_q))
    else $error("result overwritten while stalled");

endmodule
